/* rtl/core/tws_pkg.sv */
// ----------------------------------------------------------------------------
// Trie word store package
// Shared constants, the controller state type and the step control word.
// ----------------------------------------------------------------------------
package tws_pkg;

  // Default geometry of the node pool and the alphabet.
  localparam int NODE_COUNT_DEF    = 1024;
  localparam int ALPHABET_SIZE_DEF = 26;

  // Fixed width of the letter field on the input channel.
  localparam int LETTER_W = 5;

  // Operation codes carried in the op field.
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_LOOKUP = 1'b1
  } tws_op_t;

  // Controller states: clearing sweep, waiting for a word, executing a letter.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } tws_state_t;

  // Control and status produced by one letter step.
  typedef struct packed {
    logic wr_en;      // node row must be written back
    logic alloc;      // a fresh node was taken from the pool
    logic missed;     // path miss flag after this step
    logic exhausted;  // pool exhausted flag after this step
    logic is_word;    // result field, valid on a last letter
    logic is_prefix;  // result field, valid on a last letter
    logic overflow;   // result field, valid on a last letter
  } tws_step_t;

endpackage

/* rtl/core/tws_in_if.sv */
// ----------------------------------------------------------------------------
// Trie word store input channel
// One letter of a word per word transfer, with its operation and last mark.
// ----------------------------------------------------------------------------
interface tws_in_if;

  logic                          valid;
  logic                          ready;
  logic                          op;
  logic [tws_pkg::LETTER_W-1:0]  letter;
  logic                          last;

  modport source (output valid, output op, output letter, output last, input ready);
  modport sink   (input valid, input op, input letter, input last, output ready);

endinterface

/* rtl/core/tws_out_if.sv */
// ----------------------------------------------------------------------------
// Trie word store result channel
// One result word per finished input word.
// ----------------------------------------------------------------------------
interface tws_out_if;

  logic valid;
  logic ready;
  logic is_word;
  logic is_prefix;
  logic overflow;

  modport source (output valid, output is_word, output is_prefix, output overflow,
                  input ready);
  modport sink   (input valid, input is_word, input is_prefix, input overflow,
                  output ready);

endinterface

/* rtl/core/tws_step.sv */
// ----------------------------------------------------------------------------
// Trie word store letter step
// Takes the row of the current node and works out the walk for one letter:
// link follow, node allocation, word-end marking and the updated row.
// ----------------------------------------------------------------------------
module tws_step #(
  parameter int NODE_COUNT    = tws_pkg::NODE_COUNT_DEF,
  parameter int ALPHABET_SIZE = tws_pkg::ALPHABET_SIZE_DEF
) (
  input  logic                                             op,
  input  logic [tws_pkg::LETTER_W-1:0]                     letter,
  input  logic                                             last,
  input  logic [ALPHABET_SIZE*($clog2(NODE_COUNT)+1)-1:0]  row,
  input  logic [$clog2(NODE_COUNT)-1:0]                    cursor,
  input  logic [$clog2(NODE_COUNT+1)-1:0]                  next_free,
  input  logic                                             missed,
  input  logic                                             exhausted,
  output logic [ALPHABET_SIZE*($clog2(NODE_COUNT)+1)-1:0]  row_new,
  output logic [$clog2(NODE_COUNT)-1:0]                    cursor_new,
  output tws_pkg::tws_step_t                               ctl
);

  localparam int NODE_W = $clog2(NODE_COUNT);
  localparam int NF_W   = $clog2(NODE_COUNT + 1);
  localparam int SYM_W  = $clog2(ALPHABET_SIZE);
  localparam int SLOT_W = NODE_W + 1;

  // Each slot of a row holds the child's word-end mark above the child link.
  logic [SLOT_W-1:0] slot [ALPHABET_SIZE];
  logic [SYM_W-1:0]  sym;
  logic              in_range;
  logic [SLOT_W-1:0] cur_slot;
  logic [NODE_W-1:0] link;
  logic              end_mark;
  logic              pool_full;
  logic              is_insert;

  for (genvar g = 0; g < ALPHABET_SIZE; g++) begin : g_slot
    assign slot[g] = row[g*SLOT_W +: SLOT_W];
  end

  assign in_range  = 32'(letter) < 32'(ALPHABET_SIZE);
  assign sym       = SYM_W'(letter);
  assign cur_slot  = slot[sym];
  assign link      = cur_slot[NODE_W-1:0];
  assign end_mark  = cur_slot[NODE_W];
  assign pool_full = next_free == NF_W'(NODE_COUNT);
  assign is_insert = op == tws_pkg::OP_INSERT;

  // Walk decision, then the row with the selected slot replaced.
  always_comb begin
    logic              missed_n;
    logic              exh_n;
    logic              moved;
    logic              alloc;
    logic [NODE_W-1:0] child;
    logic [SLOT_W-1:0] slot_new;

    missed_n = missed;
    exh_n    = exhausted;
    moved    = 1'b0;
    alloc    = 1'b0;
    child    = link;

    // A word that has already missed or run out of nodes stays dead.
    if (!missed && !exhausted) begin
      if (!in_range) begin
        missed_n = 1'b1;
      end else if (link == '0) begin
        if (!is_insert) begin
          missed_n = 1'b1;
        end else if (pool_full) begin
          exh_n = 1'b1;
        end else begin
          alloc = 1'b1;
          moved = 1'b1;
          child = NODE_W'(next_free);
        end
      end else begin
        moved = 1'b1;
      end
    end

    // The final node of an inserted word gets its mark in the parent's slot.
    slot_new = {end_mark | (last & is_insert), child};

    row_new = row;
    for (int a = 0; a < ALPHABET_SIZE; a++) begin
      if (a == int'(sym)) begin
        row_new[a*SLOT_W +: SLOT_W] = slot_new;
      end
    end

    cursor_new    = moved ? child : cursor;
    ctl.wr_en     = alloc | (moved & last & is_insert);
    ctl.alloc     = alloc;
    ctl.missed    = missed_n;
    ctl.exhausted = exh_n;
    ctl.overflow  = exh_n;
    ctl.is_prefix = !exh_n && !missed_n;
    ctl.is_word   = !exh_n && !missed_n && (is_insert || end_mark);
  end

endmodule

/* rtl/core/trie_word_store_lookup.sv */
// ----------------------------------------------------------------------------
// Trie word store and lookup
// Prefix tree over a fixed node pool, fed one letter per word transfer.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Fields                          Transfer
//  in_ch    sink       op, letter, last                valid & ready
//  out_ch   source     is_word, is_prefix, overflow    valid & ready
//
//  Each letter first reads the current node's row from the node memory,
//  then updates the walk and writes the row back.
//  The next letter's read comes after that write-back, so no forwarding is needed.
//  After reset a clearing pass writes every node row to zero, one row a
//  cycle, and no letter is taken meanwhile.
//  A last letter waits in execution while an earlier result is not taken.
// ----------------------------------------------------------------------------
module trie_word_store_lookup #(
  parameter int NODE_COUNT    = tws_pkg::NODE_COUNT_DEF,
  parameter int ALPHABET_SIZE = tws_pkg::ALPHABET_SIZE_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  tws_in_if.sink   in_ch,
  tws_out_if.source out_ch
);

  localparam int NODE_W = $clog2(NODE_COUNT);
  localparam int NF_W   = $clog2(NODE_COUNT + 1);
  localparam int ROW_W  = ALPHABET_SIZE * (NODE_W + 1);

  tws_pkg::tws_state_t state_r, state_nxt;

  logic [NODE_W-1:0]            clr_cnt_r;
  logic [NODE_W-1:0]            cursor_r;
  logic [NF_W-1:0]              next_free_r;
  logic                         missed_r;
  logic                         exh_r;
  logic                         op_r;
  logic [tws_pkg::LETTER_W-1:0] letter_r;
  logic                         last_r;
  logic                         out_valid_r, out_valid_nxt;
  logic                         is_word_r;
  logic                         is_prefix_r;
  logic                         overflow_r;

  logic [ROW_W-1:0]  mem [NODE_COUNT];
  logic [ROW_W-1:0]  rd_row_r;
  logic              mem_re;
  logic              mem_we;
  logic [NODE_W-1:0] mem_waddr;
  logic [ROW_W-1:0]  mem_wdata;

  logic [ROW_W-1:0]   row_new;
  logic [NODE_W-1:0]  cursor_new;
  tws_pkg::tws_step_t ctl;

  logic accept;
  logic out_free;
  logic exec_go;

  // Letter step logic on the row just read.
  tws_step #(
    .NODE_COUNT    (NODE_COUNT),
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_step (
    .op         (op_r),
    .letter     (letter_r),
    .last       (last_r),
    .row        (rd_row_r),
    .cursor     (cursor_r),
    .next_free  (next_free_r),
    .missed     (missed_r),
    .exhausted  (exh_r),
    .row_new    (row_new),
    .cursor_new (cursor_new),
    .ctl        (ctl)
  );

  // Handshake and sequencing.
  assign in_ch.ready = state_r == tws_pkg::ST_IDLE;
  assign accept      = in_ch.valid && (state_r == tws_pkg::ST_IDLE);
  assign out_free    = !out_valid_r || out_ch.ready;
  assign exec_go     = (state_r == tws_pkg::ST_EXEC) && (!last_r || out_free);

  always_comb begin
    state_nxt = state_r;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = cursor_r;
    mem_wdata = row_new;
    unique case (state_r)
      tws_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        mem_wdata = '0;
        if (clr_cnt_r == NODE_W'(NODE_COUNT - 1)) begin
          state_nxt = tws_pkg::ST_IDLE;
        end
      end
      tws_pkg::ST_IDLE: begin
        mem_re = accept;
        if (accept) begin
          state_nxt = tws_pkg::ST_EXEC;
        end
      end
      tws_pkg::ST_EXEC: begin
        mem_we = exec_go && ctl.wr_en;
        if (exec_go) begin
          state_nxt = tws_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tws_pkg::ST_CLEAR;
      end
    endcase
  end

  // Result register: loaded by a last letter, freed when taken.
  always_comb begin
    if (exec_go && last_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Node memory, one row per node, with a registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_row_r <= mem[cursor_r];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tws_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      cursor_r    <= '0;
      next_free_r <= NF_W'(1);
      missed_r    <= 1'b0;
      exh_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == tws_pkg::ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + NODE_W'(1);
      end
      if (exec_go) begin
        if (ctl.alloc) begin
          next_free_r <= next_free_r + NF_W'(1);
        end
        // A finished word sends the walk back to the root.
        if (last_r) begin
          cursor_r <= '0;
          missed_r <= 1'b0;
          exh_r    <= 1'b0;
        end else begin
          cursor_r <= cursor_new;
          missed_r <= ctl.missed;
          exh_r    <= ctl.exhausted;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= in_ch.op;
      letter_r <= in_ch.letter;
      last_r   <= in_ch.last;
    end
    if (exec_go && last_r) begin
      is_word_r   <= ctl.is_word;
      is_prefix_r <= ctl.is_prefix;
      overflow_r  <= ctl.overflow;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.is_word   = is_word_r;
  assign out_ch.is_prefix = is_prefix_r;
  assign out_ch.overflow  = overflow_r;

  // The memory port never reads and writes in the same cycle.
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_re && mem_we))
    else $error("node memory read and write in the same cycle");

  // The free-node counter never passes the pool size.
  a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
    next_free_r <= NF_W'(NODE_COUNT))
    else $error("free-node counter beyond the pool");

  // The cursor always names a node that has been allocated.
  a_cursor_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    NF_W'(cursor_r) < next_free_r)
    else $error("cursor points at an unallocated node");

  // An allocation advances the free-node counter by exactly one.
  a_alloc_step: assert property (@(posedge clk) disable iff (!rst_n)
    exec_go && ctl.alloc |=> next_free_r == $past(next_free_r) + NF_W'(1))
    else $error("allocation did not advance the free-node counter");

  // A result appears only after a last letter has executed.
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(exec_go && last_r))
    else $error("result raised without a finished word");

endmodule

/* bench/tb_trie_word_store_lookup.sv */
// ----------------------------------------------------------------------------
// Testbench for the trie word store and lookup block
// Streams words one letter at a time into the prefix tree. A short table
// covers the edge cases first, then random words fill the node pool until
// it runs out or a letter cap is hit, then keep going. Each result word is checked
// against the table's verdict where given, else a behavioural trie. Both channels
// idle at random, and the result side holds off for a long stretch at least once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_trie_word_store_lookup;

  localparam int NODES        = tws_pkg::NODE_COUNT_DEF;
  localparam int ALPHA        = tws_pkg::ALPHABET_SIZE_DEF;
  localparam int SYM_W        = tws_pkg::LETTER_W;
  localparam int NODE_W       = $clog2(NODES);
  localparam int MAX_LEN      = 16;
  localparam int FILL_CAP     = 1500;
  localparam int LETTER_GOAL  = 1800;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int STORE_CAP    = 400;
  localparam int ORPHAN_CAP   = 50;

  typedef struct packed {
    logic is_word;
    logic is_prefix;
    logic overflow;
  } verdict_t;

  localparam verdict_t RES_NONE   = '{1'b0, 1'b0, 1'b0};
  localparam verdict_t RES_WORD   = '{1'b1, 1'b1, 1'b0};
  localparam verdict_t RES_PREFIX = '{1'b0, 1'b1, 1'b0};

  typedef struct packed {
    logic [MAX_LEN-1:0][SYM_W-1:0] sym;
    logic [4:0]                    len;
  } word_t;

  // One row of the directed table; the verdict counts only where typed is set.
  typedef struct packed {
    tws_pkg::tws_op_t op;
    logic [SYM_W-1:0] sym;
    logic             fin;
    logic             typed;
    verdict_t         verdict;
  } dir_row_t;

  localparam int N_DIR = 23;
  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    // Empty tree: a lookup misses.
    '{tws_pkg::OP_LOOKUP, 5'd0,  1'b1, 1'b1, RES_NONE},
    // Single letter word at the lowest letter, then found again.
    '{tws_pkg::OP_INSERT, 5'd0,  1'b1, 1'b1, RES_WORD},
    '{tws_pkg::OP_LOOKUP, 5'd0,  1'b1, 1'b1, RES_WORD},
    // Word of the highest letter, then a prefix of it that is no word.
    '{tws_pkg::OP_INSERT, 5'd25, 1'b0, 1'b0, RES_NONE},
    '{tws_pkg::OP_INSERT, 5'd25, 1'b0, 1'b0, RES_NONE},
    '{tws_pkg::OP_INSERT, 5'd25, 1'b1, 1'b1, RES_WORD},
    '{tws_pkg::OP_LOOKUP, 5'd25, 1'b0, 1'b0, RES_NONE},
    '{tws_pkg::OP_LOOKUP, 5'd25, 1'b1, 1'b1, RES_PREFIX},
    // Letter out of range on a lookup.
    '{tws_pkg::OP_LOOKUP, 5'd31, 1'b1, 1'b1, RES_NONE},
    // Letter out of range in an insert; the node made for the first letter stays.
    '{tws_pkg::OP_INSERT, 5'd1,  1'b0, 1'b0, RES_NONE},
    '{tws_pkg::OP_INSERT, 5'd26, 1'b1, 1'b1, RES_NONE},
    '{tws_pkg::OP_LOOKUP, 5'd1,  1'b1, 1'b0, RES_NONE},
    // Mixed operations, ending in a lookup that misses.
    '{tws_pkg::OP_INSERT, 5'd2,  1'b0, 1'b0, RES_NONE},
    '{tws_pkg::OP_LOOKUP, 5'd3,  1'b1, 1'b0, RES_NONE},
    // Mixed operations, ending in an insert.
    '{tws_pkg::OP_LOOKUP, 5'd0,  1'b0, 1'b0, RES_NONE},
    '{tws_pkg::OP_INSERT, 5'd24, 1'b1, 1'b0, RES_NONE},
    // A word that is dead after a miss ignores its later insert.
    '{tws_pkg::OP_LOOKUP, 5'd16, 1'b0, 1'b0, RES_NONE},
    '{tws_pkg::OP_INSERT, 5'd0,  1'b1, 1'b1, RES_NONE},
    '{tws_pkg::OP_LOOKUP, 5'd0,  1'b0, 1'b0, RES_NONE},
    '{tws_pkg::OP_LOOKUP, 5'd24, 1'b1, 1'b0, RES_NONE},
    '{tws_pkg::OP_INSERT, 5'd16, 1'b1, 1'b0, RES_NONE},
    '{tws_pkg::OP_LOOKUP, 5'd16, 1'b1, 1'b0, RES_NONE},
    '{tws_pkg::OP_INSERT, 5'd30, 1'b1, 1'b1, RES_NONE}
  };

  logic clk;
  logic rst_n;

  tws_in_if  in_ch ();
  tws_out_if out_ch ();

  trie_word_store_lookup dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Behavioural copy of the tree.
  logic [NODE_W-1:0] trie_links [NODES*ALPHA];
  bit                trie_word_end [NODES];
  int                trie_free;
  logic [NODE_W-1:0] trie_cursor;
  bit                trie_missed;
  bit                trie_exhausted;
  bit                pool_ran_out;

  verdict_t word_verdicts_due [$];
  word_t    stored_words [$];
  word_t    orphan_words [$];

  int  mismatch_count;
  int  letters_sent;
  int  words_sent;
  int  verdicts_checked;
  int  word_hits;
  int  overflows_seen;
  int  misses_seen;
  int  cycle_count;
  bit  in_calm;
  bit  out_calm;
  int  long_hold_reqs;
  int  long_holds_done;

  // Clock.
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               word_verdicts_due.size());
      $display("Verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic int draw_wait(input bit calm);
    return calm ? 0 : $urandom_range(0, 16);
  endfunction

  function automatic void trie_clear();
    for (int i = 0; i < NODES * ALPHA; i++) trie_links[i] = '0;
    for (int i = 0; i < NODES; i++) trie_word_end[i] = 1'b0;
    trie_free      = 1;
    trie_cursor    = '0;
    trie_missed    = 1'b0;
    trie_exhausted = 1'b0;
  endfunction

  // Walks one letter through the tree; returns 1 when the letter closes a word.
  function automatic bit trie_walk_letter(input tws_pkg::tws_op_t op,
                                          input logic [SYM_W-1:0] sym,
                                          input logic fin, output verdict_t verdict);
    int                slot;
    logic [NODE_W-1:0] child;
    verdict = RES_NONE;
    if (!trie_missed && !trie_exhausted) begin
      if (int'(sym) >= ALPHA) begin
        trie_missed = 1'b1;
      end else begin
        slot  = int'(trie_cursor) * ALPHA + int'(sym);
        child = trie_links[slot];
        if (child == '0) begin
          if (op == tws_pkg::OP_LOOKUP) begin
            trie_missed = 1'b1;
          end else if (trie_free >= NODES) begin
            trie_exhausted = 1'b1;
            pool_ran_out   = 1'b1;
          end else begin
            child            = trie_free[NODE_W-1:0];
            trie_free        = trie_free + 1;
            trie_links[slot] = child;
          end
        end
        if (!trie_missed && !trie_exhausted) trie_cursor = child;
      end
    end
    if (!fin) return 1'b0;

    // Close the word and return to the root.
    if (trie_exhausted) begin
      verdict.overflow = 1'b1;
    end else if (!trie_missed) begin
      if (op == tws_pkg::OP_INSERT) trie_word_end[trie_cursor] = 1'b1;
      verdict.is_word   = trie_word_end[trie_cursor];
      verdict.is_prefix = 1'b1;
    end
    trie_cursor    = '0;
    trie_missed    = 1'b0;
    trie_exhausted = 1'b0;
    return 1'b1;
  endfunction

  // Offers one letter after a random gap and waits for it to be taken.
  task automatic send_letter(input tws_pkg::tws_op_t op, input logic [SYM_W-1:0] sym,
                             input logic fin, input logic typed,
                             input verdict_t typed_verdict, output verdict_t verdict);
    int gap;
    gap = draw_wait(in_calm);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.op     <= op;
    in_ch.letter <= sym;
    in_ch.last   <= fin;
    do @(posedge clk); while (!in_ch.ready);
    letters_sent++;
    if (trie_walk_letter(op, sym, fin, verdict))
      word_verdicts_due.push_back(typed ? typed_verdict : verdict);
  endtask

  // Sends a whole word and keeps track of what ended up stored.
  task automatic send_word(input word_t w, input tws_pkg::tws_op_t op, input bit mixed);
    tws_pkg::tws_op_t step_op;
    verdict_t         verdict;
    step_op = op;
    for (int i = 0; i < int'(w.len); i++) begin
      step_op = mixed ? tws_pkg::tws_op_t'($urandom_range(0, 1)) : op;
      send_letter(step_op, w.sym[i], i == int'(w.len) - 1, 1'b0, RES_NONE, verdict);
    end
    words_sent++;
    if (step_op == tws_pkg::OP_INSERT && verdict == RES_WORD &&
        stored_words.size() < STORE_CAP)
      stored_words.push_back(w);
    if (verdict.overflow && orphan_words.size() < ORPHAN_CAP)
      orphan_words.push_back(w);
  endtask

  function automatic word_t random_word(input int lo, input int hi);
    word_t w;
    w     = '0;
    w.len = 5'($urandom_range(lo, hi));
    for (int i = 0; i < int'(w.len); i++) w.sym[i] = SYM_W'($urandom_range(0, ALPHA - 1));
    return w;
  endfunction

  // One random word; while filling, long new inserts dominate.
  task automatic random_word_item(input bit filling);
    int    pick;
    word_t w;
    if ($urandom_range(0, 9) == 0) in_calm = !in_calm;
    pick = $urandom_range(0, 99);
    if (pick < (filling ? 60 : 20)) begin
      w = filling ? random_word(6, 14) : random_word(1, 8);
      send_word(w, tws_pkg::OP_INSERT, 1'b0);
    end else if (pick < 75 && stored_words.size() > 0) begin
      // Stored word, or a prefix of one.
      w = stored_words[$urandom_range(0, stored_words.size() - 1)];
      if ($urandom_range(0, 1) == 1) w.len = 5'($urandom_range(1, int'(w.len)));
      send_word(w, tws_pkg::OP_LOOKUP, 1'b0);
    end else if (pick < 82 && stored_words.size() > 0) begin
      w = stored_words[$urandom_range(0, stored_words.size() - 1)];
      send_word(w, tws_pkg::OP_INSERT, 1'b0);
    end else if (pick < 86 && orphan_words.size() > 0) begin
      // Prefix of an insert that ran out of nodes.
      w     = orphan_words[$urandom_range(0, orphan_words.size() - 1)];
      w.len = 5'($urandom_range(1, int'(w.len)));
      send_word(w, tws_pkg::OP_LOOKUP, 1'b0);
    end else if (pick < 92) begin
      send_word(random_word(1, 5), tws_pkg::OP_LOOKUP, 1'b0);
    end else if (pick < 96) begin
      // Broken word with a letter beyond the alphabet.
      w = random_word(1, 8);
      w.sym[$urandom_range(0, int'(w.len) - 1)] = SYM_W'($urandom_range(ALPHA, 31));
      send_word(w, tws_pkg::tws_op_t'($urandom_range(0, 1)), $urandom_range(0, 1) == 1);
    end else begin
      if (stored_words.size() > 0 && $urandom_range(0, 1) == 1)
        w = stored_words[$urandom_range(0, stored_words.size() - 1)];
      else
        w = random_word(1, 6);
      send_word(w, tws_pkg::OP_INSERT, 1'b1);
    end
  endtask

  // Result side: random gaps, a long hold when asked, and the checks.
  initial begin : result_side
    int       wait_n;
    verdict_t due;
    out_ch.ready = 1'b0;
    out_calm     = 1'b1;
    forever begin
      if ($urandom_range(0, 9) == 0) out_calm = !out_calm;
      wait_n = draw_wait(out_calm);
      @(negedge clk);
      if (long_holds_done < long_hold_reqs) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        long_holds_done++;
      end else if (wait_n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (wait_n) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      if (word_verdicts_due.size() == 0) begin
        report_mismatch($sformatf("result with none outstanding (%b %b %b)",
                                  out_ch.is_word, out_ch.is_prefix, out_ch.overflow));
      end else begin
        due = word_verdicts_due.pop_front();
        if (out_ch.is_word !== due.is_word)
          report_mismatch($sformatf("result %0d is_word got %b expected %b",
                                    verdicts_checked, out_ch.is_word, due.is_word));
        if (out_ch.is_prefix !== due.is_prefix)
          report_mismatch($sformatf("result %0d is_prefix got %b expected %b",
                                    verdicts_checked, out_ch.is_prefix, due.is_prefix));
        if (out_ch.overflow !== due.overflow)
          report_mismatch($sformatf("result %0d overflow got %b expected %b",
                                    verdicts_checked, out_ch.overflow, due.overflow));
        if (due.is_word) word_hits++;
        if (due.overflow) overflows_seen++;
        if (due == RES_NONE) misses_seen++;
      end
      verdicts_checked++;
    end
  end

  // Stimulus and end of run.
  initial begin : stimulus
    verdict_t verdict;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.op     = tws_pkg::OP_INSERT;
    in_ch.letter = '0;
    in_ch.last   = 1'b0;
    in_calm      = 1'b0;
    trie_clear();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table.
    for (int i = 0; i < N_DIR; i++) begin
      send_letter(DIR_ROWS[i].op, DIR_ROWS[i].sym, DIR_ROWS[i].fin, DIR_ROWS[i].typed,
                  DIR_ROWS[i].verdict, verdict);
      if (DIR_ROWS[i].fin) words_sent++;
    end

    // Fill the node pool until it runs out or the letter cap is hit, then keep going.
    long_hold_reqs++;
    while (!pool_ran_out && letters_sent < FILL_CAP) random_word_item(1'b1);
    long_hold_reqs++;
    while (letters_sent < LETTER_GOAL) random_word_item(1'b0);

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (word_verdicts_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d letters in %0d words; checked %0d results, %0d of %0d nodes used.",
             letters_sent, words_sent, verdicts_checked, trie_free - 1, NODES - 1);
    $display("Whole-word hits %0d, overflowed inserts %0d, misses %0d, mismatches %0d.",
             word_hits, overflows_seen, misses_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
